// ===== rtl/core/cvr2d_pkg.sv =====
`timescale 1ns / 1ps

package cvr2d_pkg;

  // Geometry of the datapath
  localparam int CORDIC_STAGES = 24;
  localparam int STAGE_IDX_W   = $clog2(CORDIC_STAGES);
  localparam int ATAN_IDX_W    = 5;   // arctangent table holds 32 entries
  localparam int COORD_W       = 32;
  localparam int ANG_W         = 26;
  localparam int ANG_EXT_W     = ANG_W + 1;
  localparam int NEG_W         = COORD_W + 1;
  localparam int FRAC_BITS     = 28;
  localparam int GAIN_W        = 29;
  localparam int PROD_W        = NEG_W + GAIN_W;
  localparam int ACC_W         = 63;  // Q35.28 coordinates, headroom for CORDIC growth
  localparam int Z_W           = 42;  // degrees, 32 fractional bits
  localparam int ANG_FRAC_SH   = 16;
  localparam int RND_W         = ACC_W - FRAC_BITS;

  localparam logic signed [GAIN_W-1:0]    GAIN_Q28 = 29'sd163008219;
  localparam logic signed [ANG_EXT_W-1:0] ANG_360  = 27'sd23592960;
  localparam logic signed [ANG_EXT_W-1:0] ANG_180  = 27'sd11796480;
  localparam logic signed [ANG_EXT_W-1:0] ANG_90   = 27'sd5898240;

  localparam logic signed [ACC_W-1:0] RND_HALF    = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
  localparam logic signed [ACC_W-1:0] RND_HALF_M1 = RND_HALF - ACC_W'(64'sd1);

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct packed {
    logic signed [ACC_W-1:0] x;
    logic signed [ACC_W-1:0] y;
    logic signed [Z_W-1:0]   z;
  } cvr2d_vec_t;

  // atan(2^-i) in degrees, 32 fractional bits, rounded to nearest
  function automatic logic signed [Z_W-1:0] atan_deg(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 42'sd193273528320;
      5'd1:    v = 42'sd114096026022;
      5'd2:    v = 42'sd60285206653;
      5'd3:    v = 42'sd30601712202;
      5'd4:    v = 42'sd15360239180;
      5'd5:    v = 42'sd7687607525;
      5'd6:    v = 42'sd3844741810;
      5'd7:    v = 42'sd1922488225;
      5'd8:    v = 42'sd961258780;
      5'd9:    v = 42'sd480631223;
      5'd10:   v = 42'sd240315841;
      5'd11:   v = 42'sd120157949;
      5'd12:   v = 42'sd60078978;
      5'd13:   v = 42'sd30039489;
      5'd14:   v = 42'sd15019745;
      5'd15:   v = 42'sd7509872;
      5'd16:   v = 42'sd3754936;
      5'd17:   v = 42'sd1877468;
      5'd18:   v = 42'sd938734;
      5'd19:   v = 42'sd469367;
      5'd20:   v = 42'sd234684;
      5'd21:   v = 42'sd117342;
      5'd22:   v = 42'sd58671;
      5'd23:   v = 42'sd29335;
      5'd24:   v = 42'sd14668;
      5'd25:   v = 42'sd7334;
      5'd26:   v = 42'sd3667;
      5'd27:   v = 42'sd1833;
      5'd28:   v = 42'sd917;
      5'd29:   v = 42'sd458;
      5'd30:   v = 42'sd229;
      5'd31:   v = 42'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/cvr2d_prep.sv =====
`timescale 1ns / 1ps

// Angle wrap and quadrant fold, then gain compensation. Two register stages.
module cvr2d_prep (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic signed [cvr2d_pkg::COORD_W-1:0] x_i,
  input  logic signed [cvr2d_pkg::COORD_W-1:0] y_i,
  input  logic signed [cvr2d_pkg::ANG_W-1:0]   angle_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output cvr2d_pkg::cvr2d_vec_t                vec_o
);
  import cvr2d_pkg::*;

  logic                        f_valid_q, m_valid_q;
  logic                        f_ready, m_ready;
  logic signed [NEG_W-1:0]     fx_d, fy_d, fx_q, fy_q;
  logic signed [ANG_EXT_W-1:0] a_ext, a_wrap, fa_d, fa_q;
  logic signed [PROD_W-1:0]    px, py;
  cvr2d_vec_t                  vec_d, vec_q;

  assign m_ready = !m_valid_q || ready_i;
  assign f_ready = !f_valid_q || m_ready;
  assign ready_o = f_ready;

  // wrap into +-180, then fold into +-90 with the point negated
  always_comb begin
    a_ext = ANG_EXT_W'(angle_i);
    if (a_ext > ANG_180) begin
      a_wrap = a_ext - ANG_360;
    end else if (a_ext < -ANG_180) begin
      a_wrap = a_ext + ANG_360;
    end else begin
      a_wrap = a_ext;
    end
    fx_d = NEG_W'(x_i);
    fy_d = NEG_W'(y_i);
    fa_d = a_wrap;
    if (a_wrap > ANG_90) begin
      fa_d = a_wrap - ANG_180;
      fx_d = -NEG_W'(x_i);
      fy_d = -NEG_W'(y_i);
    end else if (a_wrap < -ANG_90) begin
      fa_d = a_wrap + ANG_180;
      fx_d = -NEG_W'(x_i);
      fy_d = -NEG_W'(y_i);
    end
  end

  assign px = fx_q * GAIN_Q28;
  assign py = fy_q * GAIN_Q28;

  always_comb begin
    vec_d.x = ACC_W'(px);
    vec_d.y = ACC_W'(py);
    vec_d.z = Z_W'(fa_q) <<< ANG_FRAC_SH;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (f_ready) f_valid_q <= valid_i;
      if (m_ready) m_valid_q <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f_ready && valid_i) begin
      fx_q <= fx_d;
      fy_q <= fy_d;
      fa_q <= fa_d;
    end
    if (m_ready && f_valid_q) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = m_valid_q;
  assign vec_o   = vec_q;

endmodule

// ===== rtl/core/cvr2d_cell.sv =====
`timescale 1ns / 1ps

// One CORDIC rotation-mode micro-rotation with its own output register.
module cvr2d_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [cvr2d_pkg::STAGE_IDX_W-1:0]   stage_idx_i,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  cvr2d_pkg::cvr2d_vec_t               vec_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output cvr2d_pkg::cvr2d_vec_t               vec_o
);
  import cvr2d_pkg::*;

  logic                    valid_q;
  logic signed [ACC_W-1:0] dx, dy;
  logic signed [Z_W-1:0]   at;
  cvr2d_vec_t              vec_d, vec_q;

  assign ready_o = !valid_q || ready_i;

  assign dx = vec_i.y >>> stage_idx_i;
  assign dy = vec_i.x >>> stage_idx_i;
  assign at = atan_deg(ATAN_IDX_W'(stage_idx_i));

  always_comb begin
    if (!vec_i.z[Z_W-1]) begin
      vec_d.x = vec_i.x - dx;
      vec_d.y = vec_i.y + dy;
      vec_d.z = vec_i.z - at;
    end else begin
      vec_d.x = vec_i.x + dx;
      vec_d.y = vec_i.y - dy;
      vec_d.z = vec_i.z + at;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) vec_q <= vec_d;
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

// ===== rtl/core/cvr2d_post.sv =====
`timescale 1ns / 1ps

// Round half away from zero, then clamp to the coordinate range. The second
// register is the block's output register.
module cvr2d_post (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  cvr2d_pkg::cvr2d_vec_t                vec_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [cvr2d_pkg::COORD_W-1:0] x_o,
  output logic signed [cvr2d_pkg::COORD_W-1:0] y_o,
  output logic                                 sat_o
);
  import cvr2d_pkg::*;

  logic                      r_valid_q, o_valid_q;
  logic                      r_ready, o_ready;
  logic signed [ACC_W-1:0]   bx, by;
  logic signed [RND_W-1:0]   rx_q, ry_q;
  logic                      ovf_x, ovf_y;
  logic signed [COORD_W-1:0] cx_d, cy_d, x_q, y_q;
  logic                      sat_q;

  assign o_ready = !o_valid_q || ready_i;
  assign r_ready = !r_valid_q || o_ready;
  assign ready_o = r_ready;

  // negative values take half minus one, which turns the floor into ties-away
  assign bx = vec_i.x + (vec_i.x[ACC_W-1] ? RND_HALF_M1 : RND_HALF);
  assign by = vec_i.y + (vec_i.y[ACC_W-1] ? RND_HALF_M1 : RND_HALF);

  assign ovf_x = (rx_q[RND_W-1:COORD_W-1] != {(RND_W-COORD_W+1){rx_q[RND_W-1]}});
  assign ovf_y = (ry_q[RND_W-1:COORD_W-1] != {(RND_W-COORD_W+1){ry_q[RND_W-1]}});

  always_comb begin
    cx_d = rx_q[COORD_W-1:0];
    cy_d = ry_q[COORD_W-1:0];
    if (ovf_x) cx_d = rx_q[RND_W-1] ? COORD_MIN : COORD_MAX;
    if (ovf_y) cy_d = ry_q[RND_W-1] ? COORD_MIN : COORD_MAX;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (r_ready) r_valid_q <= valid_i;
      if (o_ready) o_valid_q <= r_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_ready && valid_i) begin
      rx_q <= bx[ACC_W-1:FRAC_BITS];
      ry_q <= by[ACC_W-1:FRAC_BITS];
    end
    if (o_ready && r_valid_q) begin
      x_q   <= cx_d;
      y_q   <= cy_d;
      sat_q <= ovf_x || ovf_y;
    end
  end

  assign valid_o = o_valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign sat_o   = sat_q;

endmodule

// ===== rtl/core/cordic_vector_rotate_2d_core.sv =====
`timescale 1ns / 1ps
// Pipeline: 2 prep registers, 24 CORDIC cells, 2 rounding/clamp registers.
// Throughput: one transaction per cycle while the output accepts; every stage holds
//   its own register and valid bit, so bubbles close up and a stalled output only
//   halts what sits behind it.
// Reset: rst_ni asynchronous, active low, clears all valid bits; data registers keep
//   whatever they hold.

module cordic_vector_rotate_2d_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input transaction
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [95:0] s_axis_tdata_i,   // [31:0] x_in, [63:32] y_in, [89:64] angle, rest zero
  // result transaction
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // [31:0] x_out, [63:32] y_out
  output logic [0:0]  m_axis_tuser_o    // [0] saturated
);
  import cvr2d_pkg::*;

  // Unpack the input transaction
  logic signed [COORD_W-1:0] x_in, y_in;
  logic signed [ANG_W-1:0]   angle;

  assign x_in  = s_axis_tdata_i[COORD_W-1:0];
  assign y_in  = s_axis_tdata_i[2*COORD_W-1:COORD_W];
  assign angle = s_axis_tdata_i[2*COORD_W+ANG_W-1:2*COORD_W];

  // Chain signals: index 0 is the prep output, index CORDIC_STAGES feeds post.
  logic       ch_valid [CORDIC_STAGES+1];
  logic       ch_ready [CORDIC_STAGES+1];
  cvr2d_vec_t ch_vec   [CORDIC_STAGES+1];

  // Angle fold plus gain multiply
  cvr2d_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .x_i     (x_in),
    .y_i     (y_in),
    .angle_i (angle),
    .valid_o (ch_valid[0]),
    .ready_i (ch_ready[0]),
    .vec_o   (ch_vec[0])
  );

  // Row of micro-rotation cells; each cell learns its shift and arctangent
  // from its position in the row.
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    cvr2d_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .stage_idx_i (STAGE_IDX_W'(g)),
      .valid_i     (ch_valid[g]),
      .ready_o     (ch_ready[g]),
      .vec_i       (ch_vec[g]),
      .valid_o     (ch_valid[g+1]),
      .ready_i     (ch_ready[g+1]),
      .vec_o       (ch_vec[g+1])
    );
  end

  // Rounding, saturation and the output register
  logic signed [COORD_W-1:0] x_out, y_out;
  logic                      saturated;

  cvr2d_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ch_valid[CORDIC_STAGES]),
    .ready_o (ch_ready[CORDIC_STAGES]),
    .vec_i   (ch_vec[CORDIC_STAGES]),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .x_o     (x_out),
    .y_o     (y_out),
    .sat_o   (saturated)
  );

  assign m_axis_tdata_o = {y_out, x_out};
  assign m_axis_tuser_o = saturated;

endmodule

// ===== rtl/core/cvr2d_checker.sv =====
`timescale 1ns / 1ps

module cvr2d_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic [0:0]  m_axis_tuser_o
);
  import cvr2d_pkg::*;

  logic at_bound;

  assign at_bound = (m_axis_tdata_o[31:0] == COORD_MAX) || (m_axis_tdata_o[31:0] == COORD_MIN) ||
                    (m_axis_tdata_o[63:32] == COORD_MAX) || (m_axis_tdata_o[63:32] == COORD_MIN);

  // a stalled result stays offered
  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result payload changed while stalled");

  // saturation flag only with a clamped coordinate
  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> at_bound)
    else $error("saturated without a clamped coordinate");

  // nothing is offered when reset is released
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result offered straight out of reset");

  // while the output register stays empty, the input is ready
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!m_axis_tvalid_o) && $past(m_axis_tready_i) && !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with an empty output");

endmodule

bind cordic_vector_rotate_2d_core cvr2d_checker u_cvr2d_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
